[sv/mlt_pkg.sv]
// shared types, constants and the symbol lookup for the markup line tokenizer
// no dependencies; used by every module of the block
package mlt_pkg;

    localparam int MAX_TEXT_DEF = 63;
    localparam int CHAR_W       = 8;
    localparam int KIND_W       = 5;
    localparam int NUM_SYMS     = 20;

    localparam logic [KIND_W-1:0] KIND_TEXT        = 5'd20;
    localparam logic [KIND_W-1:0] KIND_NUMBER      = 5'd21;
    localparam logic [KIND_W-1:0] KIND_NEWLINE     = 5'd0;
    localparam logic [KIND_W-1:0] FIRST_SPACE_KIND = 5'd13;

    localparam logic [CHAR_W-1:0] CHAR_BACKSLASH = 8'h5C;
    localparam logic [CHAR_W-1:0] CHAR_ZERO      = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_ONE       = 8'h31;
    localparam logic [CHAR_W-1:0] CHAR_NINE      = 8'h39;
    localparam logic [CHAR_W-1:0] CHAR_DOT       = 8'h2E;

    // symbol set, position is the token kind
    localparam logic [CHAR_W-1:0] SYMSET [NUM_SYMS] = '{
        8'h0A, 8'h5F, 8'h2A, 8'h60, 8'h3D, 8'h2D, 8'h2B, 8'h3C, 8'h23, 8'h21,
        8'h5B, 8'h3E, 8'h7E, 8'h20, 8'h5D, 8'h28, 8'h29, 8'h22, 8'h3A, 8'h00
    };

    typedef struct packed {
        logic              hit;
        logic [KIND_W-1:0] kind;
    } sym_match_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_EMIT,
        ST_SYM
    } ctrl_state_t;

    // controller to datapath
    typedef struct packed {
        logic accept;        // capture symbol char and kind
        logic append;        // add char to text buffer
        logic rd_start;      // restart buffer read at entry zero
        logic emit_text;     // load next buffered char into output
        logic text_run_last; // that char ends the item's results
        logic emit_sym;      // load captured symbol into output
        logic clear_text;    // empty the buffer and drop overflow
    } mlt_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic sym_hit;
        logic esc_ok;
        logic is_bs;
        logic eol;
        logic count_nz;
        logic text_last;
        logic out_free;
    } mlt_status_t;

    function automatic sym_match_t sym_lookup(input logic [CHAR_W-1:0] c);
        sym_match_t m;
        m.hit  = 1'b0;
        m.kind = KIND_NEWLINE;
        for (int i = NUM_SYMS - 1; i >= 0; i--) begin
            if (SYMSET[i] == c) begin
                m.hit  = 1'b1;
                m.kind = KIND_W'(i);
            end
        end
        return m;
    endfunction

    function automatic logic is_digit(input logic [CHAR_W-1:0] c);
        return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
    endfunction

endpackage

[sv/mlt_ctrl.sv]
// controller state machine of the markup line tokenizer
// depends on mlt_pkg; drives mlt_datapath through command and status structs
module mlt_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  mlt_pkg::mlt_status_t st,
    output mlt_pkg::mlt_cmd_t    cmd
);

    mlt_pkg::ctrl_state_t state_reg, state_next;
    logic esc_reg, esc_next;
    logic sym_pend_reg, sym_pend_next;

    logic take, sym_take, append, flush, text_go;

    // item decode
    always_comb begin
        take     = s_valid && (state_reg == mlt_pkg::ST_IDLE);
        sym_take = esc_reg ? st.esc_ok : (!st.is_bs && st.sym_hit);
        append   = esc_reg ? !st.esc_ok : (!st.is_bs && !st.sym_hit);
        flush    = sym_take || (!esc_reg && st.is_bs) || st.eol;
        text_go  = flush && (st.count_nz || append);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= mlt_pkg::ST_IDLE;
            esc_reg      <= 1'b0;
            sym_pend_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            esc_reg      <= esc_next;
            sym_pend_reg <= sym_pend_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            mlt_pkg::ST_IDLE: begin
                if (take) begin
                    if (text_go)       state_next = mlt_pkg::ST_READ;
                    else if (sym_take) state_next = mlt_pkg::ST_SYM;
                end
            end
            mlt_pkg::ST_READ: begin
                state_next = mlt_pkg::ST_EMIT;
            end
            mlt_pkg::ST_EMIT: begin
                if (st.out_free) begin
                    if (!st.text_last)    state_next = mlt_pkg::ST_READ;
                    else if (sym_pend_reg) state_next = mlt_pkg::ST_SYM;
                    else                  state_next = mlt_pkg::ST_IDLE;
                end
            end
            mlt_pkg::ST_SYM: begin
                if (st.out_free) state_next = mlt_pkg::ST_IDLE;
            end
            default: state_next = mlt_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        esc_next      = take ? (!esc_reg && st.is_bs && !st.eol) : esc_reg;
        sym_pend_next = take ? sym_take : sym_pend_reg;
        s_ready       = 1'b0;
        cmd           = '0;
        unique case (state_reg)
            mlt_pkg::ST_IDLE: begin
                s_ready        = 1'b1;
                cmd.accept     = take;
                cmd.append     = take && append;
                cmd.rd_start   = take && text_go;
                cmd.clear_text = take && flush && !text_go;
            end
            mlt_pkg::ST_READ: begin
                cmd = '0;
            end
            mlt_pkg::ST_EMIT: begin
                cmd.emit_text     = st.out_free;
                cmd.text_run_last = st.text_last && !sym_pend_reg;
                cmd.clear_text    = st.out_free && st.text_last;
            end
            mlt_pkg::ST_SYM: begin
                cmd.emit_sym = st.out_free;
            end
            default: cmd = '0;
        endcase
    end

endmodule

[sv/mlt_datapath.sv]
// datapath of the markup line tokenizer: text memory, number tracking, output register
// depends on mlt_pkg; commanded by mlt_ctrl
module mlt_datapath #(
    parameter int MAX_TEXT = mlt_pkg::MAX_TEXT_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic [mlt_pkg::CHAR_W-1:0]  s_char_in,
    input  logic                        s_end_of_line,
    input  logic                        m_ready,
    output logic                        m_valid,
    output logic [mlt_pkg::KIND_W-1:0]  m_token_kind,
    output logic                        m_op_flag,
    output logic [mlt_pkg::CHAR_W-1:0]  m_char_out,
    output logic                        m_token_end,
    output logic                        m_truncated,
    output logic                        m_run_last,
    input  mlt_pkg::mlt_cmd_t           cmd,
    output mlt_pkg::mlt_status_t        st
);

    localparam int CNT_W  = $clog2(MAX_TEXT + 1);
    localparam int ADDR_W = $clog2(MAX_TEXT);
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_TEXT);
    localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);
    localparam logic [CNT_W-1:0] CNT_TWO = CNT_W'(2);

    logic [mlt_pkg::CHAR_W-1:0] text_mem [MAX_TEXT];
    logic [mlt_pkg::CHAR_W-1:0] rd_data_reg;

    logic [CNT_W-1:0]  count_reg;
    logic [ADDR_W-1:0] idx_reg;
    logic              ovf_reg;
    logic              first_ok_reg, mid_ok_reg;
    logic [mlt_pkg::CHAR_W-1:0] last_char_reg;

    logic [mlt_pkg::CHAR_W-1:0] sym_char_reg;
    logic [mlt_pkg::KIND_W-1:0] sym_kind_reg;

    logic                       m_valid_reg;
    logic [mlt_pkg::KIND_W-1:0] kind_reg;
    logic                       op_reg, end_reg, trunc_reg, last_reg;
    logic [mlt_pkg::CHAR_W-1:0] char_reg;

    mlt_pkg::sym_match_t match;
    logic                room;
    logic                is_num;

    always_comb begin
        match        = mlt_pkg::sym_lookup(s_char_in);
        room         = count_reg < MAX_CNT;
        is_num       = (count_reg >= CNT_TWO) && first_ok_reg && mid_ok_reg
                       && (last_char_reg == mlt_pkg::CHAR_DOT);
        st.sym_hit   = match.hit;
        st.esc_ok    = match.hit && ((match.kind == mlt_pkg::KIND_NEWLINE)
                       || (match.kind >= mlt_pkg::FIRST_SPACE_KIND));
        st.is_bs     = s_char_in == mlt_pkg::CHAR_BACKSLASH;
        st.eol       = s_end_of_line;
        st.count_nz  = count_reg != '0;
        st.text_last = (CNT_W'(idx_reg) + CNT_ONE) == count_reg;
        st.out_free  = !m_valid_reg || m_ready;
    end

    // text memory, one write and one registered read port
    always_ff @(posedge aclk) begin
        if (cmd.append && room) begin
            text_mem[count_reg[ADDR_W-1:0]] <= s_char_in;
        end
        rd_data_reg <= text_mem[idx_reg];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            ovf_reg   <= 1'b0;
            idx_reg   <= '0;
        end else begin
            if (cmd.clear_text) begin
                count_reg <= '0;
                ovf_reg   <= 1'b0;
            end else if (cmd.append) begin
                if (room) count_reg <= count_reg + CNT_ONE;
                else      ovf_reg   <= 1'b1;
            end
            if (cmd.rd_start)       idx_reg <= '0;
            else if (cmd.emit_text) idx_reg <= idx_reg + ADDR_W'(1);
        end
    end

    // running number check on the buffered text
    always_ff @(posedge aclk) begin
        if (cmd.append && room) begin
            last_char_reg <= s_char_in;
            if (count_reg == '0) begin
                first_ok_reg <= (s_char_in >= mlt_pkg::CHAR_ONE)
                                && (s_char_in <= mlt_pkg::CHAR_NINE);
                mid_ok_reg   <= 1'b1;
            end else if (count_reg >= CNT_TWO) begin
                mid_ok_reg   <= mid_ok_reg && mlt_pkg::is_digit(last_char_reg);
            end
        end
        if (cmd.accept) begin
            sym_char_reg <= s_char_in;
            sym_kind_reg <= match.kind;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.emit_text || cmd.emit_sym) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit_text) begin
            kind_reg  <= is_num ? mlt_pkg::KIND_NUMBER : mlt_pkg::KIND_TEXT;
            op_reg    <= is_num;
            char_reg  <= rd_data_reg;
            end_reg   <= st.text_last;
            trunc_reg <= ovf_reg;
            last_reg  <= cmd.text_run_last;
        end else if (cmd.emit_sym) begin
            kind_reg  <= sym_kind_reg;
            op_reg    <= sym_kind_reg < mlt_pkg::FIRST_SPACE_KIND;
            char_reg  <= sym_char_reg;
            end_reg   <= 1'b1;
            trunc_reg <= 1'b0;
            last_reg  <= 1'b1;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_token_kind = kind_reg;
    assign m_op_flag    = op_reg;
    assign m_char_out   = char_reg;
    assign m_token_end  = end_reg;
    assign m_truncated  = trunc_reg;
    assign m_run_last   = last_reg;

endmodule

[sv/markup_line_tokenizer_core.sv]
// Markup line tokenizer. Takes one character per item and returns zero or more
// token characters. A character that only joins the text buffer gives no result
// and leaves the block ready for the next item. An item that flushes buffered
// characters passes each through ST_READ and ST_EMIT, waiting in ST_EMIT until
// the output register is free, then a following symbol through ST_SYM; ST_READ
// is needed as the text memory has a single registered read port. Items are
// worked one at a time, but the output register lets the next item in while the
// last result waits for m_ready. Text beyond MAX_TEXT characters is dropped and
// the token carries m_truncated. There is no clearing pass after reset.
// depends on mlt_pkg, mlt_ctrl, mlt_datapath
module markup_line_tokenizer_core #(
    parameter int MAX_TEXT = mlt_pkg::MAX_TEXT_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    // input item channel
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [mlt_pkg::CHAR_W-1:0]  s_char_in,
    input  logic                        s_end_of_line,
    // result item channel
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [mlt_pkg::KIND_W-1:0]  m_token_kind,
    output logic                        m_op_flag,
    output logic [mlt_pkg::CHAR_W-1:0]  m_char_out,
    output logic                        m_token_end,
    output logic                        m_truncated,
    output logic                        m_run_last
);

    // commands and status between controller and datapath
    mlt_pkg::mlt_cmd_t    cmd;
    mlt_pkg::mlt_status_t st;

    // sequencer: decodes the item, steps through a flush and the symbol
    mlt_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .st      (st),
        .cmd     (cmd)
    );

    // text buffer, number tracking and the output register
    mlt_datapath #(
        .MAX_TEXT (MAX_TEXT)
    ) u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_char_in     (s_char_in),
        .s_end_of_line (s_end_of_line),
        .m_ready       (m_ready),
        .m_valid       (m_valid),
        .m_token_kind  (m_token_kind),
        .m_op_flag     (m_op_flag),
        .m_char_out    (m_char_out),
        .m_token_end   (m_token_end),
        .m_truncated   (m_truncated),
        .m_run_last    (m_run_last),
        .cmd           (cmd),
        .st            (st)
    );

    // a result is only loaded when the output register is free
    a_load_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.emit_text || cmd.emit_sym) |-> st.out_free)
        else $error("result loaded over a held result");

    // text and symbol never loaded in the same cycle
    a_one_source: assert property (@(posedge aclk) disable iff (!aresetn)
        !(cmd.emit_text && cmd.emit_sym))
        else $error("text and symbol loaded together");

    // a symbol ends the item, so the block is ready right after it
    a_sym_then_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit_sym |=> s_ready)
        else $error("not ready after symbol");

    // an item that ends its results leaves the block ready
    a_run_last_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.emit_text && cmd.text_run_last) |=> s_ready)
        else $error("not ready after last text result");

endmodule
